>>> design/cbq_pkg.sv
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types and constants of the cascaded biquad equaliser.
// ----------------------------------------------------------------------------
package cbq_pkg;

   // coefficient slots of one band, also the order of the product terms
   localparam logic [2:0] SLOT_B0 = 3'd0;
   localparam logic [2:0] SLOT_B1 = 3'd1;
   localparam logic [2:0] SLOT_B2 = 3'd2;
   localparam logic [2:0] SLOT_A1 = 3'd3;
   localparam logic [2:0] SLOT_A2 = 3'd4;
   localparam int         N_SLOTS = 5;

   // configuration register indexes
   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_STEREO = 1'b1;

   // channel tags carried along the chain
   localparam logic CH_LEFT  = 1'b0;
   localparam logic CH_RIGHT = 1'b1;

   // cell sequencing
   localparam logic [3:0] STEP_LAST_MUL = 4'd9;
   localparam logic [3:0] STEP_REDUCE   = 4'd11;

   // sample fraction bits and PCM limits
   localparam int                SFRAC   = 12;
   localparam logic signed [15:0] PCM_MAX = 16'sd32767;
   localparam logic signed [15:0] PCM_MIN = -16'sd32768;

   typedef struct packed {
      logic       wr;
      logic       clear;
      logic [2:0] band;
      logic [2:0] slot;
   } cell_ctrl_type;

   typedef struct packed {
      logic vld;
      logic ch;
   } token_type;

endpackage

>>> design/cbq_cell.sv
// ----------------------------------------------------------------------------
// cbq_cell
// One biquad band: coefficients, per-channel history and a shared
// multiply-accumulate that works through the five terms in halves.
// ----------------------------------------------------------------------------
module cbq_cell #(
   parameter int IDX          = 0,
   parameter int COEF_WIDTH   = 32,
   parameter int SIGNAL_WIDTH = 40
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cbq_pkg::cell_ctrl_type         ctrl,
   input  logic signed [COEF_WIDTH-1:0]   coef_value,
   input  cbq_pkg::token_type             in_tok,
   input  logic signed [SIGNAL_WIDTH-1:0] in_x,
   output cbq_pkg::token_type             out_tok,
   output logic signed [SIGNAL_WIDTH-1:0] out_y
);

   localparam int CFRAC  = COEF_WIDTH - 4;
   localparam int LO_W   = SIGNAL_WIDTH / 2;
   localparam int HI_W   = SIGNAL_WIDTH - LO_W;
   localparam int OP_W   = HI_W + 1;
   localparam int PROD_W = COEF_WIDTH + OP_W;
   localparam int ACC_W  = COEF_WIDTH + SIGNAL_WIDTH + 3;

   logic signed [COEF_WIDTH-1:0]   coef_ff [cbq_pkg::N_SLOTS];
   logic signed [SIGNAL_WIDTH-1:0] x1_ff [2];
   logic signed [SIGNAL_WIDTH-1:0] x2_ff [2];
   logic signed [SIGNAL_WIDTH-1:0] y1_ff [2];
   logic signed [SIGNAL_WIDTH-1:0] y2_ff [2];
   logic signed [SIGNAL_WIDTH-1:0] x_ff;
   logic                           ch_ff;
   logic                           busy_ff;
   logic [3:0]                     step_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic                           prod_vld_ff, prod_hi_ff, prod_sub_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic signed [SIGNAL_WIDTH-1:0] out_y_ff;
   logic                           out_vld_ff;
   logic                           out_ch_ff;

   logic [2:0]                     term;
   logic signed [SIGNAL_WIDTH-1:0] sig;
   logic signed [COEF_WIDTH-1:0]   coef_sel;
   logic signed [OP_W-1:0]         op;
   logic signed [PROD_W-1:0]       prod_in;
   logic signed [ACC_W-1:0]        term_ext;
   logic signed [ACC_W-1:0]        acc_in;
   logic signed [ACC_W-1:0]        shifted;
   logic                           in_range;
   logic signed [SIGNAL_WIDTH-1:0] y_sat;
   logic                           coef_hit;

   assign term = step_ff[3:1];

   always_comb begin
      case (term)
         cbq_pkg::SLOT_B0: begin
            sig      = x_ff;
            coef_sel = coef_ff[0];
         end
         cbq_pkg::SLOT_B1: begin
            sig      = x1_ff[ch_ff];
            coef_sel = coef_ff[1];
         end
         cbq_pkg::SLOT_B2: begin
            sig      = x2_ff[ch_ff];
            coef_sel = coef_ff[2];
         end
         cbq_pkg::SLOT_A1: begin
            sig      = y1_ff[ch_ff];
            coef_sel = coef_ff[3];
         end
         default: begin
            sig      = y2_ff[ch_ff];
            coef_sel = coef_ff[4];
         end
      endcase
      // low half unsigned, high half signed and weighted by 2^LO_W
      if (step_ff[0]) begin
         op = OP_W'($signed(sig[SIGNAL_WIDTH-1:LO_W]));
      end else begin
         op = OP_W'({1'b0, sig[LO_W-1:0]});
      end
      prod_in = coef_sel * op;
   end

   always_comb begin
      term_ext = ACC_W'(prod_ff);
      if (prod_hi_ff) begin
         term_ext = term_ext <<< LO_W;
      end
      acc_in = prod_sub_ff ? acc_ff - term_ext : acc_ff + term_ext;
   end

   always_comb begin
      shifted  = acc_ff >>> CFRAC;
      in_range = (&shifted[ACC_W-1:SIGNAL_WIDTH-1]) | ~(|shifted[ACC_W-1:SIGNAL_WIDTH-1]);
      if (in_range) begin
         y_sat = shifted[SIGNAL_WIDTH-1:0];
      end else if (shifted[ACC_W-1]) begin
         y_sat = {1'b1, {(SIGNAL_WIDTH-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SIGNAL_WIDTH-1){1'b1}}};
      end
   end

   assign coef_hit = ctrl.wr && (int'(ctrl.band) == IDX);

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         step_ff     <= '0;
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         out_vld_ff <= 1'b0;
         if (in_tok.vld) begin
            busy_ff     <= 1'b1;
            step_ff     <= '0;
            prod_vld_ff <= 1'b0;
         end else if (busy_ff) begin
            prod_vld_ff <= (step_ff <= cbq_pkg::STEP_LAST_MUL);
            if (step_ff == cbq_pkg::STEP_REDUCE) begin
               busy_ff    <= 1'b0;
               out_vld_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 4'd1;
            end
         end else begin
            prod_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_tok.vld) begin
         x_ff   <= in_x;
         ch_ff  <= in_tok.ch;
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
      prod_ff     <= prod_in;
      prod_hi_ff  <= step_ff[0];
      prod_sub_ff <= (term == cbq_pkg::SLOT_A1) || (term == cbq_pkg::SLOT_A2);
      if (busy_ff && step_ff == cbq_pkg::STEP_REDUCE) begin
         out_y_ff  <= y_sat;
         out_ch_ff <= ch_ff;
      end
   end

   // coefficients and histories
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < cbq_pkg::N_SLOTS; s++) begin
            coef_ff[s] <= (s == 0) ? (COEF_WIDTH'(1) <<< CFRAC) : '0;
         end
         for (int c = 0; c < 2; c++) begin
            x1_ff[c] <= '0;
            x2_ff[c] <= '0;
            y1_ff[c] <= '0;
            y2_ff[c] <= '0;
         end
      end else begin
         if (coef_hit) begin
            for (int s = 0; s < cbq_pkg::N_SLOTS; s++) begin
               if (int'(ctrl.slot) == s) begin
                  coef_ff[s] <= coef_value;
               end
            end
         end
         if (ctrl.clear) begin
            for (int c = 0; c < 2; c++) begin
               x1_ff[c] <= '0;
               x2_ff[c] <= '0;
               y1_ff[c] <= '0;
               y2_ff[c] <= '0;
            end
         end else if (busy_ff && step_ff == cbq_pkg::STEP_REDUCE) begin
            x2_ff[ch_ff] <= x1_ff[ch_ff];
            x1_ff[ch_ff] <= x_ff;
            y2_ff[ch_ff] <= y1_ff[ch_ff];
            y1_ff[ch_ff] <= y_sat;
         end
      end
   end

   assign out_tok.vld = out_vld_ff;
   assign out_tok.ch  = out_ch_ff;
   assign out_y       = out_y_ff;

endmodule

>>> design/cascaded_biquad_equalizer_core.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer_core
// Stereo equaliser: a chain of biquad cells, one per band, fed in turn by
// the left and right sample of each frame, or the left alone in mono mode.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries sample frames (req_cmd low) and coefficient writes
//   (req_cmd high). An item is taken when req_valid is high and req_stall
//   low. A coefficient write leaves req_stall low, gives no item on rsp_*
//   and clears all histories; a write to an absent band or slot is dropped.
//   Each frame gives one item on rsp_*, held until rsp_stall is low.
//   A band cell's single multiplier steps through five terms in two halves
//   each per channel sample; the right sample enters the first cell as the
//   left one moves on, so channels overlap by cell.
//   req_stall is high from a frame's acceptance until its result moves to
//   the output register, which waits until any previous result is taken.
//   csr_* writes enable and stereo; the user must write them only while
//   idle, which the block itself does not enforce. Clearing enable clears
//   all histories. Reset restores unity coefficients, clears histories and
//   sets enable and stereo.
// ----------------------------------------------------------------------------
module cascaded_biquad_equalizer_core #(
   parameter int BANDS        = 5,
   parameter int COEF_WIDTH   = 32,
   parameter int SIGNAL_WIDTH = 40
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [15:0] req_left_in,
   input  logic signed [15:0] req_right_in,
   input  logic [2:0]         req_coef_band,
   input  logic [2:0]         req_coef_slot,
   input  logic signed [31:0] req_coef_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic               csr_data
);

   localparam int SW  = SIGNAL_WIDTH;
   localparam int SFR = cbq_pkg::SFRAC;
   localparam logic signed [SW:0] PCM_HI = (SW+1)'(cbq_pkg::PCM_MAX);
   localparam logic signed [SW:0] PCM_LO = (SW+1)'(cbq_pkg::PCM_MIN);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_POST} state_type;

   state_type          state_ff;
   logic               enable_ff, stereo_ff;
   logic               mono_ff;
   logic signed [15:0] right_ff;
   logic signed [15:0] res_left_ff, res_right_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_left_ff, rsp_right_ff;

   logic                         accept;
   logic                         start_left;
   cbq_pkg::cell_ctrl_type       ctrl;
   logic signed [COEF_WIDTH-1:0] coef_conv;
   cbq_pkg::token_type           tok_in [BANDS];
   cbq_pkg::token_type           tok_out [BANDS];
   logic signed [SW-1:0]         x_in [BANDS];
   logic signed [SW-1:0]         y_out [BANDS];
   logic signed [SW-1:0]         y_last;
   logic                         rnd_up;
   logic signed [SW:0]           q_round;
   logic signed [15:0]           pcm;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign start_left = accept && !req_cmd && enable_ff;

   always_comb begin
      ctrl.band  = req_coef_band;
      ctrl.slot  = req_coef_slot;
      ctrl.wr    = accept && req_cmd && (int'(req_coef_band) < BANDS)
                   && (req_coef_slot <= cbq_pkg::SLOT_A2);
      ctrl.clear = ctrl.wr
                   || (csr_write && csr_index == cbq_pkg::CSR_ENABLE && !csr_data);
   end

   // Q4.28 input moved to the stored coefficient format
   generate
      if (COEF_WIDTH >= 32) begin : g_coef_wide
         assign coef_conv = COEF_WIDTH'(req_coef_value) <<< (COEF_WIDTH - 32);
      end else begin : g_coef_narrow
         assign coef_conv = COEF_WIDTH'(req_coef_value >>> (32 - COEF_WIDTH));
      end
   endgenerate

   // first cell takes left at acceptance, right in stereo once left moves on
   always_comb begin
      tok_in[0].vld = start_left
                      || (tok_out[0].vld && tok_out[0].ch == cbq_pkg::CH_LEFT && !mono_ff);
      tok_in[0].ch  = start_left ? cbq_pkg::CH_LEFT : cbq_pkg::CH_RIGHT;
      x_in[0]       = start_left ? (SW'(req_left_in) <<< SFR) : (SW'(right_ff) <<< SFR);
   end

   generate
      for (genvar b = 0; b < BANDS; b++) begin : g_band
         if (b > 0) begin : g_link
            assign tok_in[b] = tok_out[b-1];
            assign x_in[b]   = y_out[b-1];
         end
         cbq_cell #(
            .IDX          (b),
            .COEF_WIDTH   (COEF_WIDTH),
            .SIGNAL_WIDTH (SIGNAL_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .coef_value (coef_conv),
            .in_tok     (tok_in[b]),
            .in_x       (x_in[b]),
            .out_tok    (tok_out[b]),
            .out_y      (y_out[b])
         );
      end
   endgenerate

   // round half to even, then saturate to PCM
   assign y_last  = y_out[BANDS-1];
   assign rnd_up  = y_last[SFR-1] && ((|y_last[SFR-2:0]) || y_last[SFR]);
   assign q_round = (SW+1)'($signed(y_last[SW-1:SFR])) + (SW+1)'(rnd_up);

   always_comb begin
      if (q_round > PCM_HI) begin
         pcm = cbq_pkg::PCM_MAX;
      end else if (q_round < PCM_LO) begin
         pcm = cbq_pkg::PCM_MIN;
      end else begin
         pcm = q_round[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         stereo_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            cbq_pkg::CSR_ENABLE: enable_ff <= csr_data;
            cbq_pkg::CSR_STEREO: stereo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_POST the output register is refilled below instead
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_POST) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && !req_cmd) begin
                  mono_ff      <= !stereo_ff;
                  right_ff     <= req_right_in;
                  res_left_ff  <= req_left_in;
                  res_right_ff <= req_right_in;
                  state_ff     <= enable_ff ? ST_RUN : ST_POST;
               end
            end
            ST_RUN: begin
               if (tok_out[BANDS-1].vld) begin
                  if (tok_out[BANDS-1].ch == cbq_pkg::CH_LEFT) begin
                     res_left_ff <= pcm;
                     if (mono_ff) begin
                        state_ff <= ST_POST;
                     end
                  end else begin
                     res_right_ff <= pcm;
                     state_ff     <= ST_POST;
                  end
               end
            end
            ST_POST: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_left_ff  <= res_left_ff;
                  rsp_right_ff <= res_right_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

>>> design/cbq_checker.sv
// ----------------------------------------------------------------------------
// cbq_checker
// Port-level checks of the equaliser's item flow, bound to the top level.
// ----------------------------------------------------------------------------
module cbq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_cmd,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_left_out,
   input logic signed [15:0] rsp_right_out
);

   // a held result item does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_out)
                                 && $stable(rsp_right_out))
      else $error("result item changed while stalled");

   // a coefficient write does not stall the input
   a_coef_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd |=> !req_stall)
      else $error("busy after coefficient write");

   // a frame keeps the input stalled while it is worked on
   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_cmd |=> req_stall)
      else $error("frame accepted without going busy");

   // a new result only appears at the end of a busy period
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item without a frame in flight");

endmodule

bind cascaded_biquad_equalizer_core cbq_checker u_cbq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_cmd       (req_cmd),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out)
);
